FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_MAX_ROWS   = 32;
   localparam int DEF_CELL_COUNT = 4096;

   // Register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTRIBUTE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_OFFSET    = 3'd4;

   localparam logic [4:0]  RST_TAB_WIDTH = 5'd8;
   localparam logic [7:0]  RST_ATTRIBUTE = 8'h07;
   localparam logic [7:0]  RST_COLUMNS   = 8'd80;
   localparam logic [5:0]  RST_ROWS      = 6'd25;
   localparam logic [15:0] RST_PAGE      = 16'd0;

   // Character codes
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7F;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS_OLD,
      ST_APPLY,
      ST_TAB_DIV,
      ST_TAB_APPLY,
      ST_SCROLL_COPY,
      ST_SCROLL_DRAIN,
      ST_SCROLL_FILL,
      ST_POS_NEW,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic pos_calc;
      logic apply;
      logic div_start;
      logic div_step;
      logic tab_apply;
      logic scroll_start;
      logic copy_step;
      logic fill_start;
      logic fill_step;
      logic clear_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_tab;
      logic apply_scroll;
      logic tab_scroll;
      logic copy_empty;
      logic copy_last;
      logic fill_last;
      logic div_done;
      logic rsp_free;
   } status_type;

   function automatic int width_of(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: design/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = tccw_pkg::DEF_CELL_COUNT
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [tccw_pkg::width_of(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [tccw_pkg::width_of(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/tccw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tccw_pkg::status_type status,
   output tccw_pkg::cmd_type         cmd
);

   tccw_pkg::state_type state_ff;
   tccw_pkg::state_type state_in;
   logic                take;

   // New item can enter when idle, or as the finished result leaves.
   assign take = req_valid &&
                 ((state_ff == tccw_pkg::ST_IDLE) ||
                  ((state_ff == tccw_pkg::ST_RESP) && status.rsp_free));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tccw_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = tccw_pkg::ST_IDLE;
         end
         tccw_pkg::ST_IDLE: begin
            if (take) state_in = tccw_pkg::ST_POS_OLD;
         end
         tccw_pkg::ST_POS_OLD: begin
            state_in = tccw_pkg::ST_APPLY;
         end
         tccw_pkg::ST_APPLY: begin
            if (status.is_tab) begin
               state_in = tccw_pkg::ST_TAB_DIV;
            end else if (status.apply_scroll) begin
               state_in = status.copy_empty ? tccw_pkg::ST_SCROLL_FILL
                                            : tccw_pkg::ST_SCROLL_COPY;
            end else begin
               state_in = tccw_pkg::ST_POS_NEW;
            end
         end
         tccw_pkg::ST_TAB_DIV: begin
            if (status.div_done) state_in = tccw_pkg::ST_TAB_APPLY;
         end
         tccw_pkg::ST_TAB_APPLY: begin
            if (status.tab_scroll) begin
               state_in = status.copy_empty ? tccw_pkg::ST_SCROLL_FILL
                                            : tccw_pkg::ST_SCROLL_COPY;
            end else begin
               state_in = tccw_pkg::ST_POS_NEW;
            end
         end
         tccw_pkg::ST_SCROLL_COPY: begin
            if (status.copy_last) state_in = tccw_pkg::ST_SCROLL_DRAIN;
         end
         tccw_pkg::ST_SCROLL_DRAIN: begin
            state_in = tccw_pkg::ST_SCROLL_FILL;
         end
         tccw_pkg::ST_SCROLL_FILL: begin
            if (status.fill_last) state_in = tccw_pkg::ST_POS_NEW;
         end
         tccw_pkg::ST_POS_NEW: begin
            state_in = tccw_pkg::ST_RESP;
         end
         tccw_pkg::ST_RESP: begin
            if (take) begin
               state_in = tccw_pkg::ST_POS_OLD;
            end else if (status.rsp_free) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.accept = take;
      req_ready  = 1'b0;
      case (state_ff)
         tccw_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         tccw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         tccw_pkg::ST_POS_OLD: begin
            cmd.pos_calc = 1'b1;
         end
         tccw_pkg::ST_APPLY: begin
            cmd.apply        = 1'b1;
            cmd.div_start    = status.is_tab;
            cmd.scroll_start = !status.is_tab && status.apply_scroll;
         end
         tccw_pkg::ST_TAB_DIV: begin
            cmd.div_step = 1'b1;
         end
         tccw_pkg::ST_TAB_APPLY: begin
            cmd.tab_apply    = 1'b1;
            cmd.scroll_start = status.tab_scroll;
         end
         tccw_pkg::ST_SCROLL_COPY: begin
            cmd.copy_step = 1'b1;
         end
         tccw_pkg::ST_SCROLL_DRAIN: begin
            cmd.fill_start = 1'b1;
         end
         tccw_pkg::ST_SCROLL_FILL: begin
            cmd.fill_step = 1'b1;
         end
         tccw_pkg::ST_POS_NEW: begin
            cmd.pos_calc = 1'b1;
         end
         tccw_pkg::ST_RESP: begin
            cmd.rsp_load = status.rsp_free;
            req_ready    = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tccw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_datapath #(
   parameter int MAX_COLS   = tccw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = tccw_pkg::DEF_MAX_ROWS,
   parameter int CELL_COUNT = tccw_pkg::DEF_CELL_COUNT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tccw_pkg::cmd_type               cmd,
   output tccw_pkg::status_type                 status,
   input  wire logic                            req_func,
   input  wire logic [7:0]                      req_char_code,
   input  wire logic [11:0]                     req_cell_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [15:0]                          rsp_cell_data,
   output logic [6:0]                           rsp_cursor_col,
   output logic [4:0]                           rsp_cursor_row,
   output logic [15:0]                          rsp_cursor_position,
   output logic                                 rsp_scrolled,
   input  wire logic                            csr_valid,
   input  wire logic [tccw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [15:0]                     csr_data
);

   localparam int COL_W  = tccw_pkg::width_of(MAX_COLS);
   localparam int ROW_W  = tccw_pkg::width_of(MAX_ROWS);
   localparam int NC_W   = tccw_pkg::width_of(MAX_COLS + 1);
   localparam int NR_W   = tccw_pkg::width_of(MAX_ROWS + 1);
   localparam int AREA_W = tccw_pkg::width_of(MAX_COLS * MAX_ROWS + 1);
   localparam int SPAN   = (MAX_COLS * MAX_ROWS > CELL_COUNT) ? MAX_COLS * MAX_ROWS
                                                              : CELL_COUNT;
   localparam int PTR_W  = tccw_pkg::width_of(SPAN + 1);
   localparam int ADDR_W = tccw_pkg::width_of(CELL_COUNT);
   localparam int CW     = COL_W + 1;
   localparam int CN_W   = COL_W + 6;
   localparam int DCNT_W = tccw_pkg::width_of(CW + 1);

   // Configuration
   logic [4:0]  tab_ff,  tab_in;
   logic [7:0]  attr_ff, attr_in;
   logic [7:0]  cols_ff, cols_in;
   logic [5:0]  rows_ff, rows_in;
   logic [15:0] page_ff, page_in;

   // Item and cursor
   logic             func_ff;
   logic [7:0]       ch_ff;
   logic [11:0]      idx_ff;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic             scrolled_ff, scrolled_in;
   logic [AREA_W-1:0] pos_ff;
   logic [AREA_W-1:0] area_ff;

   // Scroll and clear sweep
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] dst_ff;
   logic             pend_ff;

   // Tab remainder unit
   logic [4:0]        div_rem_ff, div_rem_in;
   logic [CW-1:0]     div_num_ff, div_num_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [5:0]        rem_sh;

   // Result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [6:0]  rsp_col_ff;
   logic [4:0]  rsp_row_ff;
   logic [15:0] rsp_pos_ff;
   logic        rsp_scr_ff;

   logic [NC_W-1:0]  nc;
   logic [NR_W-1:0]  nr;
   logic [4:0]       tab_eff;
   logic [CW-1:0]    col_inc;
   logic [ROW_W:0]   row_inc;
   logic             wrap;
   logic             nl_scroll;
   logic [ROW_W-1:0] nl_row;
   logic             put_nl;
   logic             printable;
   logic             cell_we;
   logic [CN_W-1:0]  tab_cn;
   logic             tab_wrap;
   logic [PTR_W-1:0] fill_base;
   logic [PTR_W-1:0] area_last;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [15:0]       ram_rdata;

   // Clamp the geometry and tab width
   always_comb begin
      if (cols_ff == '0) begin
         nc = NC_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         nc = NC_W'(MAX_COLS);
      end else begin
         nc = NC_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         nr = NR_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         nr = NR_W'(MAX_ROWS);
      end else begin
         nr = NR_W'(rows_ff);
      end
      tab_eff = (tab_ff == '0) ? 5'd1 : tab_ff;
   end

   assign col_inc   = CW'(cur_col_ff) + CW'(1);
   assign row_inc   = (ROW_W + 1)'(cur_row_ff) + (ROW_W + 1)'(1);
   assign wrap      = col_inc >= nc;
   assign nl_scroll = row_inc >= nr;
   assign nl_row    = nl_scroll ? ROW_W'(nr - NR_W'(1)) : ROW_W'(row_inc);
   assign put_nl    = (ch_ff == tccw_pkg::CH_LF) ||
                      ((ch_ff != tccw_pkg::CH_CR) && (ch_ff != tccw_pkg::CH_TAB) &&
                       (ch_ff != tccw_pkg::CH_BS) && wrap);
   assign printable = (ch_ff >= tccw_pkg::CH_PRINT_LO) && (ch_ff <= tccw_pkg::CH_PRINT_HI);
   assign cell_we   = cmd.apply && !func_ff && printable && (cur_col_ff < nc) &&
                      (cur_row_ff < nr) && (int'(pos_ff) < CELL_COUNT);

   assign tab_cn    = (div_rem_ff == '0) ? CN_W'(col_inc)
                      : CN_W'(col_inc) + CN_W'(tab_eff) - CN_W'(div_rem_ff);
   assign tab_wrap  = tab_cn >= nc;
   assign rem_sh    = {div_rem_ff, div_num_ff[CW-1]};

   assign fill_base = PTR_W'(area_ff) - PTR_W'(nc);
   assign area_last = PTR_W'(area_ff) - PTR_W'(1);

   always_comb begin
      status              = '0;
      status.clear_last   = ptr_ff == PTR_W'(CELL_COUNT - 1);
      status.is_tab       = !func_ff && (ch_ff == tccw_pkg::CH_TAB);
      status.apply_scroll = !func_ff && put_nl && nl_scroll;
      status.tab_scroll   = tab_wrap && nl_scroll;
      status.copy_empty   = nr == NR_W'(1);
      status.copy_last    = ptr_ff == area_last;
      status.fill_last    = ptr_ff == area_last;
      status.div_done     = div_cnt_ff == '0;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Configuration writes
   always_comb begin
      tab_in  = tab_ff;
      attr_in = attr_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      page_in = page_ff;
      if (csr_valid) begin
         case (csr_index)
            tccw_pkg::CSR_TAB_WIDTH:      tab_in  = csr_data[4:0];
            tccw_pkg::CSR_TEXT_ATTRIBUTE: attr_in = csr_data[7:0];
            tccw_pkg::CSR_COLUMNS:        cols_in = csr_data[7:0];
            tccw_pkg::CSR_ROWS:           rows_in = csr_data[5:0];
            tccw_pkg::CSR_PAGE_OFFSET:    page_in = csr_data;
            default:                      tab_in  = tab_ff;
         endcase
      end
   end

   // Cursor movement
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      scrolled_in = scrolled_ff;
      if (cmd.accept) begin
         scrolled_in = 1'b0;
      end
      if (cmd.apply && !func_ff) begin
         if (put_nl) begin
            cur_col_in  = '0;
            cur_row_in  = nl_row;
            scrolled_in = nl_scroll;
         end else if (ch_ff == tccw_pkg::CH_CR) begin
            cur_col_in = '0;
         end else if (ch_ff == tccw_pkg::CH_BS) begin
            if (cur_col_ff != '0) cur_col_in = cur_col_ff - COL_W'(1);
         end else if (ch_ff != tccw_pkg::CH_TAB) begin
            cur_col_in = COL_W'(col_inc);
         end
      end
      if (cmd.tab_apply) begin
         if (tab_wrap) begin
            cur_col_in  = '0;
            cur_row_in  = nl_row;
            scrolled_in = nl_scroll;
         end else begin
            cur_col_in = COL_W'(tab_cn);
         end
      end
   end

   // Sweep pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.scroll_start) begin
         ptr_in = status.copy_empty ? fill_base : PTR_W'(nc);
      end else if (cmd.fill_start) begin
         ptr_in = fill_base;
      end else if (cmd.clear_step || cmd.copy_step || cmd.fill_step) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
   end

   // Bit-serial remainder of (column + 1) by the tab width
   always_comb begin
      div_rem_in = div_rem_ff;
      div_num_in = div_num_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_rem_in = '0;
         div_num_in = col_inc;
         div_cnt_in = DCNT_W'(CW);
      end else if (cmd.div_step && (div_cnt_ff != '0)) begin
         div_rem_in = (rem_sh >= {1'b0, tab_eff}) ? 5'(rem_sh - {1'b0, tab_eff})
                                                  : rem_sh[4:0];
         div_num_in = div_num_ff << 1;
         div_cnt_in = div_cnt_ff - DCNT_W'(1);
      end
   end

   // Screen store write port: clear, pending copy, bottom-row fill, character
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(pos_ff);
      ram_wdata = {attr_ff, ch_ff};
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = ADDR_W'(ptr_ff);
         ram_wdata = '0;
      end else if (pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = ADDR_W'(dst_ff);
         ram_wdata = ram_rdata;
      end else if (cmd.fill_step) begin
         ram_we    = int'(ptr_ff) < CELL_COUNT;
         ram_waddr = ADDR_W'(ptr_ff);
         ram_wdata = {attr_ff, 8'h00};
      end else if (cell_we) begin
         ram_we = 1'b1;
      end
   end

   assign ram_raddr = cmd.copy_step ? ADDR_W'(ptr_ff) : ADDR_W'(idx_ff);

   tccw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff       <= tccw_pkg::RST_TAB_WIDTH;
         attr_ff      <= tccw_pkg::RST_ATTRIBUTE;
         cols_ff      <= tccw_pkg::RST_COLUMNS;
         rows_ff      <= tccw_pkg::RST_ROWS;
         page_ff      <= tccw_pkg::RST_PAGE;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         scrolled_ff  <= 1'b0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tab_ff       <= tab_in;
         attr_ff      <= attr_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         page_ff      <= page_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         scrolled_ff  <= scrolled_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= cmd.copy_step && (int'(ptr_ff) < CELL_COUNT);
         div_cnt_ff   <= div_cnt_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         ch_ff   <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      if (cmd.pos_calc) begin
         pos_ff <= AREA_W'(AREA_W'(cur_row_ff) * AREA_W'(nc)) + AREA_W'(cur_col_ff);
      end
      area_ff    <= AREA_W'(AREA_W'(nc) * AREA_W'(nr));
      dst_ff     <= ptr_ff - PTR_W'(nc);
      div_rem_ff <= div_rem_in;
      div_num_ff <= div_num_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= (func_ff && (int'(idx_ff) < CELL_COUNT)) ? ram_rdata : 16'h0000;
         rsp_col_ff  <= 7'(cur_col_ff);
         rsp_row_ff  <= 5'(cur_row_ff);
         rsp_pos_ff  <= page_ff + 16'(pos_ff);
         rsp_scr_ff  <= scrolled_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_data       = rsp_data_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_scrolled        = rsp_scr_ff;

endmodule

`default_nettype wire

FILE: design/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   req_func, req_char_code, req_cell_index
// rsp      out  rsp_valid/rsp_ready   rsp_cell_data, rsp_cursor_col/_row/_position,
//                                     rsp_scrolled
// csr      in   csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// One item at a time: reads and plain characters pass through the old position multiply,
// apply, new position multiply and result load steps; a tab also runs the bit-serial
// remainder unit before the tab is applied.
// A scroll copies one cell per cycle through the screen RAM (skipped with a single row),
// then, after a drain step, fills one bottom-row cell per cycle.
// After reset the screen RAM is cleared one cell per cycle, all CELL_COUNT cells
// (4096 by default), with req_ready low; csr writes are taken throughout.
// A stalled result holds in the output register; the next item's result waits behind it.

module text_console_char_writer_core #(
   parameter int MAX_COLS   = tccw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = tccw_pkg::DEF_MAX_ROWS,
   parameter int CELL_COUNT = tccw_pkg::DEF_CELL_COUNT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic [7:0]                      req_char_code,
   input  wire logic [11:0]                     req_cell_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [15:0]                          rsp_cell_data,
   output logic [6:0]                           rsp_cursor_col,
   output logic [4:0]                           rsp_cursor_row,
   output logic [15:0]                          rsp_cursor_position,
   output logic                                 rsp_scrolled,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tccw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [15:0]                     csr_data
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_datapath #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .CELL_COUNT (CELL_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_data       (rsp_cell_data),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

`default_nettype wire

FILE: design/tccw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tccw_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [15:0]                     rsp_cell_data,
   input wire logic [6:0]                      rsp_cursor_col,
   input wire logic [15:0]                     rsp_cursor_position,
   input wire logic                            rsp_scrolled
);

   // Screen clear holds off items right after reset.
   `ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready, "item taken during clear")

   // One item in flight: no second accept on the following edge.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   // A scroll only comes from a new line, which parks the cursor at column 0.
   `ASSERT_IMP(a_scroll_col_zero, clock, reset, rsp_valid && rsp_scrolled, rsp_cursor_col == 7'd0, "scroll with nonzero column")

   // Reads never scroll, and character items return no cell data.
   `ASSERT_IMP(a_scroll_no_data, clock, reset, rsp_valid && rsp_scrolled, rsp_cell_data == 16'h0000, "scroll with cell data")

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cursor_position) && $stable(rsp_cell_data), "result changed while stalled")

endmodule

bind text_console_char_writer_core tccw_checker u_tccw_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;
   localparam int   PRINT_LIMIT = 40;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [15:0] position;
      logic        scrolled;
   } cursor_report_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_func;
   logic [7:0]                     req_char_code;
   logic [11:0]                    req_cell_index;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [15:0]                    rsp_cell_data;
   logic [6:0]                     rsp_cursor_col;
   logic [4:0]                     rsp_cursor_row;
   logic [15:0]                    rsp_cursor_position;
   logic                           rsp_scrolled;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [tccw_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                    csr_data;

   // shadow of the console: screen, cursor and registers
   logic [15:0] screen_copy [tccw_pkg::DEF_CELL_COUNT];
   int          cursor_col;
   int          cursor_row;
   logic [4:0]  tab_reg;
   logic [7:0]  attr_reg;
   logic [7:0]  cols_reg;
   logic [5:0]  rows_reg;
   logic [15:0] page_reg;

   cursor_report_type cursor_reports[$];
   int error_count = 0;
   int result_count = 0;
   bit req_steady = 0;
   bit rsp_steady = 0;
   int hold_off_cycles = 0;

   text_console_char_writer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cell_data       (rsp_cell_data),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_scrolled        (rsp_scrolled),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(40_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int eff_columns();
      if (cols_reg == 0) return 1;
      if (cols_reg > tccw_pkg::DEF_MAX_COLS) return tccw_pkg::DEF_MAX_COLS;
      return int'(cols_reg);
   endfunction

   function automatic int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > tccw_pkg::DEF_MAX_ROWS) return tccw_pkg::DEF_MAX_ROWS;
      return int'(rows_reg);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // move to column 0 of the next row, scrolling when past the last row
   task automatic next_line(input int nc, input int nr, output bit scrolled);
      int area;
      cursor_col = 0;
      cursor_row++;
      scrolled = 1'b0;
      if (cursor_row >= nr) begin
         cursor_row = nr - 1;
         area = nc * nr;
         for (int i = 0; i + nc < area; i++) screen_copy[i] = screen_copy[i + nc];
         for (int i = area - nc; i < area; i++) screen_copy[i] = {attr_reg, 8'h00};
         scrolled = 1'b1;
      end
   endtask

   task automatic console_step(input logic func, input logic [7:0] ch, input logic [11:0] idx,
                               output cursor_report_type want);
      int nc;
      int nr;
      int t;
      int c;
      int pos;
      bit scrolled;
      nc = eff_columns();
      nr = eff_rows();
      scrolled = 1'b0;
      want = '0;
      if (func == FUNC_READ) begin
         want.cell_data = screen_copy[idx];
      end else begin
         if (ch >= tccw_pkg::CH_PRINT_LO && ch <= tccw_pkg::CH_PRINT_HI) begin
            pos = cursor_row * nc + cursor_col;
            // drop writes that land outside the active area
            if (cursor_col < nc && cursor_row < nr && pos < tccw_pkg::DEF_CELL_COUNT)
               screen_copy[pos] = {attr_reg, ch};
         end
         case (ch)
            tccw_pkg::CH_LF: next_line(nc, nr, scrolled);
            tccw_pkg::CH_CR: cursor_col = 0;
            tccw_pkg::CH_TAB: begin
               t = (tab_reg == 0) ? 1 : int'(tab_reg);
               c = cursor_col + 1;
               c = ((c + t - 1) / t) * t;
               if (c >= nc) next_line(nc, nr, scrolled);
               else cursor_col = c;
            end
            tccw_pkg::CH_BS: if (cursor_col > 0) cursor_col--;
            default: begin
               if (cursor_col + 1 >= nc) next_line(nc, nr, scrolled);
               else cursor_col++;
            end
         endcase
      end
      pos = int'(page_reg) + cursor_row * nc + cursor_col;
      want.col = 7'(cursor_col);
      want.row = 5'(cursor_row);
      want.position = 16'(pos);
      want.scrolled = scrolled;
   endtask

   task automatic check_report(input cursor_report_type got);
      cursor_report_type want;
      result_count++;
      if (cursor_reports.size() == 0) begin
         report_error($sformatf("result %0d arrived with nothing pending", result_count));
         return;
      end
      want = cursor_reports.pop_front();
      if (got.cell_data !== want.cell_data)
         report_error($sformatf("result %0d cell_data %h, want %h",
                                result_count, got.cell_data, want.cell_data));
      if (got.col !== want.col)
         report_error($sformatf("result %0d cursor_col %0d, want %0d",
                                result_count, got.col, want.col));
      if (got.row !== want.row)
         report_error($sformatf("result %0d cursor_row %0d, want %0d",
                                result_count, got.row, want.row));
      if (got.position !== want.position)
         report_error($sformatf("result %0d cursor_position %h, want %h",
                                result_count, got.position, want.position));
      if (got.scrolled !== want.scrolled)
         report_error($sformatf("result %0d scrolled %b, want %b",
                                result_count, got.scrolled, want.scrolled));
   endtask

   // result side: random stalls per item, plus a long hold-off on request
   initial begin : rsp_side
      int stall;
      cursor_report_type got;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_cell_data, rsp_cursor_col, rsp_cursor_row, rsp_cursor_position,
                   rsp_scrolled};
            check_report(got);
            stall = rsp_steady ? 0 : $urandom_range(0, 4);
         end
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic func, input logic [7:0] ch, input logic [11:0] idx);
      int gap;
      cursor_report_type want;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_char_code <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (!req_ready);
      console_step(func, ch, idx, want);
      cursor_reports.push_back(want);
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_item(FUNC_PUT, ch, 12'($urandom));
   endtask

   task automatic read_cell(input logic [11:0] idx);
      send_item(FUNC_READ, 8'($urandom), idx);
   endtask

   // drop valid and let every pending result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cursor_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_registers(input logic [15:0] tab, input logic [15:0] attr,
                                  input logic [15:0] cols, input logic [15:0] rows,
                                  input logic [15:0] page);
      logic [tccw_pkg::CSR_IDX_W-1:0] reg_ids [5];
      logic [15:0]                    values  [5];
      reg_ids = '{tccw_pkg::CSR_TAB_WIDTH, tccw_pkg::CSR_TEXT_ATTRIBUTE,
                  tccw_pkg::CSR_COLUMNS, tccw_pkg::CSR_ROWS, tccw_pkg::CSR_PAGE_OFFSET};
      values = '{tab, attr, cols, rows, page};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_ids[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
         case (reg_ids[i])
            tccw_pkg::CSR_TAB_WIDTH:      tab_reg = values[i][4:0];
            tccw_pkg::CSR_TEXT_ATTRIBUTE: attr_reg = values[i][7:0];
            tccw_pkg::CSR_COLUMNS:        cols_reg = values[i][7:0];
            tccw_pkg::CSR_ROWS:           rows_reg = values[i][5:0];
            tccw_pkg::CSR_PAGE_OFFSET:    page_reg = values[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 58) return 8'($urandom_range(tccw_pkg::CH_PRINT_LO, tccw_pkg::CH_PRINT_HI));
      if (r < 70) return tccw_pkg::CH_LF;
      if (r < 76) return tccw_pkg::CH_CR;
      if (r < 84) return tccw_pkg::CH_TAB;
      if (r < 90) return tccw_pkg::CH_BS;
      return 8'($urandom);
   endfunction

   // runs at reset settings: 80 x 25, tab 8, attribute 07
   task automatic test_basic_chars();
      read_cell(12'h000);
      read_cell(12'hFFF);
      put_char(tccw_pkg::CH_PRINT_LO);
      put_char(tccw_pkg::CH_PRINT_HI);
      put_char(8'h41);
      put_char(tccw_pkg::CH_BS);
      put_char(tccw_pkg::CH_CR);
      put_char(tccw_pkg::CH_BS);
      put_char(tccw_pkg::CH_TAB);
      put_char(tccw_pkg::CH_TAB);
      put_char(8'h80);
      put_char(8'hFF);
      put_char(8'h00);
      put_char(8'h1F);
      put_char(tccw_pkg::CH_LF);
      read_cell(12'h000);
      read_cell(12'h001);
      read_cell(12'h002);
   endtask

   task automatic test_config_extremes();
      wait_idle();
      // zero width, rows and tab clamp to one
      write_registers(16'd0, 16'h00FF, 16'd0, 16'd0, 16'hFFFF);
      put_char(8'h78);
      put_char(8'h79);
      read_cell(12'h000);
      put_char(tccw_pkg::CH_TAB);
      put_char(tccw_pkg::CH_BS);
      put_char(tccw_pkg::CH_LF);
      read_cell(12'h001);
      wait_idle();
      // oversized columns and rows clamp to the maxima
      write_registers(16'd31, 16'h0080, 16'd255, 16'd63, 16'h1234);
      repeat (5) put_char(tccw_pkg::CH_TAB);
      put_char(tccw_pkg::CH_PRINT_HI);
      put_char(tccw_pkg::CH_CR);
      read_cell(12'd128);
      read_cell(12'hFFF);
      wait_idle();
      write_registers(16'd16, 16'h0000, 16'd128, 16'd32, 16'h0000);
      put_char(tccw_pkg::CH_TAB);
      put_char(tccw_pkg::CH_TAB);
      put_char(8'h7A);
   endtask

   task automatic random_config();
      int c;
      int r;
      int ec;
      int er;
      int pick;
      logic [15:0] page;
      pick = $urandom_range(0, 9);
      c = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(128, 255) : $urandom_range(1, 16);
      pick = $urandom_range(0, 9);
      r = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(32, 63) : $urandom_range(1, 8);
      ec = (c == 0) ? 1 : (c > tccw_pkg::DEF_MAX_COLS) ? tccw_pkg::DEF_MAX_COLS : c;
      er = (r == 0) ? 1 : (r > tccw_pkg::DEF_MAX_ROWS) ? tccw_pkg::DEF_MAX_ROWS : r;
      // keep scrolls short here; the full screen gets its own test
      if (ec * er > 512) r = $urandom_range(1, 4);
      page = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFC0, 16'hFFFF))
                                          : 16'($urandom);
      write_registers({11'($urandom), 5'($urandom_range(0, 31))},
                      {8'($urandom), 8'($urandom)},
                      {8'($urandom), 8'(c)},
                      {10'($urandom), 6'(r)},
                      page);
   endtask

   task automatic random_items(input int count);
      int area;
      logic [11:0] idx;
      for (int n = 0; n < count; n++) begin
         area = eff_columns() * eff_rows();
         if ($urandom_range(0, 99) < 15) begin
            idx = ($urandom_range(0, 2) != 0) ? 12'($urandom_range(0, area - 1))
                                               : 12'($urandom);
            read_cell(idx);
         end else begin
            put_char(pick_char());
         end
      end
   endtask

   task automatic test_random_text();
      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         random_config();
         req_steady = (phase % 4 == 1) || (phase % 4 == 3 && phase > 4);
         rsp_steady = (phase % 4 == 1) || (phase % 4 == 2 && phase > 4);
         random_items(40);
      end
      req_steady = 0;
      rsp_steady = 0;
   endtask

   task automatic test_full_screen();
      int r;
      wait_idle();
      write_registers(16'd4, 16'h001E, 16'd128, 16'd32, 16'hFFFE);
      for (int n = 0; n < 40; n++) begin
         r = $urandom_range(0, 99);
         if (r < 60) put_char(tccw_pkg::CH_LF);
         else if (r < 90)
            put_char(8'($urandom_range(tccw_pkg::CH_PRINT_LO, tccw_pkg::CH_PRINT_HI)));
         else read_cell(12'($urandom));
      end
   endtask

   // receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      wait_idle();
      write_registers(16'd3, 16'h0042, 16'd6, 16'd3, 16'h0100);
      hold_off_cycles = 300;
      random_items(12);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_PUT;
      req_char_code <= 8'h00;
      req_cell_index <= 12'h000;
      csr_valid <= 1'b0;
      csr_index <= tccw_pkg::CSR_TAB_WIDTH;
      csr_data <= 16'h0000;
      for (int i = 0; i < tccw_pkg::DEF_CELL_COUNT; i++) screen_copy[i] = 16'h0000;
      cursor_col = 0;
      cursor_row = 0;
      tab_reg = tccw_pkg::RST_TAB_WIDTH;
      attr_reg = tccw_pkg::RST_ATTRIBUTE;
      cols_reg = tccw_pkg::RST_COLUMNS;
      rows_reg = tccw_pkg::RST_ROWS;
      page_reg = tccw_pkg::RST_PAGE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_chars();
      test_config_extremes();
      test_backpressure();
      test_random_text();
      test_full_screen();

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
